/* rtl/vnh_pkg.sv */
// Package for the value noise heightmap unit: constants, types and helper functions.
// Used by the top level, the octave and hash modules and the testbench; depends on nothing.
`timescale 1ns / 1ps
package vnh_pkg;

	localparam int OCTAVES = 3;
	localparam int MAX_LAYERS = 5;
	localparam int OCT_N = (OCTAVES > MAX_LAYERS) ? MAX_LAYERS : OCTAVES;

	localparam logic [31:0] HPRIME = 32'hFFFF_FFFB;
	localparam logic [31:0] HMUL = 32'd1103515245;
	localparam logic [31:0] HXMUL = 32'd73856093;
	localparam logic [31:0] HZMUL = 32'd19349663;
	localparam logic [31:0] HADD = 32'd12345;
	localparam logic [31:0] XOFF = 32'd1013;
	localparam logic [31:0] ZOFF = 32'd7919;

	localparam int HASH_LAT = 6;
	localparam int OCT_LAT = 1 + HASH_LAT + 4;
	localparam int TOP_LAT = OCT_LAT + 2;
	localparam int SUM_W = 74;

	typedef logic [31:0] word_t;
	typedef logic [61:0] layer_t;
	typedef logic [SUM_W-1:0] sum_t;

	// Reduces a 64-bit value modulo 2^32 - 5, using 2^32 = 5 modulo the prime.
	function automatic word_t mod_p(input logic [63:0] v);
		logic [34:0] t1;
		logic [32:0] t2;
		t1 = 35'(v[31:0]) + 35'(v[63:32]) * 35'd5;
		t2 = 33'(t1[31:0]) + 33'(t1[34:32]) * 33'd5;
		if (t2 >= 33'(HPRIME)) begin
			t2 = t2 - 33'(HPRIME);
		end
		return t2[31:0];
	endfunction

	// Exact smoothstep weight k^2 (96 - 2k) for k in 0..31, scaled by 2^15.
	function automatic logic [14:0] smooth(input logic [4:0] k);
		logic [19:0] kk;
		kk = 20'(k) * 20'(k) * (20'd96 - 20'(k) * 20'd2);
		return kk[14:0];
	endfunction

endpackage

/* rtl/value_noise_heightmap_unit.sv */
// Top level of the value noise heightmap unit: seed register, octave lanes, final sum.
// Depends on vnh_pkg and vnh_octave.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_stall   cell_x, cell_z
//   result   out        out_valid / out_stall height
//   config   in         cfg_valid / cfg_ready cfg_data (seed)
//
// One cell is accepted per cycle while the result is not stalled.
// The depth is set by the three modular multiply-reduce steps of the corner hash
// and the two multiply steps of the bilinear blend.
// Reset clears the valid bits and sets the seed to zero.
// A stalled result freezes the whole pipeline, and in_stall follows it.
`timescale 1ns / 1ps
module value_noise_heightmap_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] cell_x,
	input  logic signed [23:0] cell_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         height,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        cfg_data
);
	import vnh_pkg::*;

	logic en;
	word_t seed_q;
	logic [TOP_LAT-1:0] vld_s;
	layer_t n_o [OCT_N];
	sum_t w_c, w_s12, t3;
	logic [4:0] height_s13;

	assign en = !(vld_s[TOP_LAT-1] && out_stall);
	assign in_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_valid) begin
			seed_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[TOP_LAT-2:0], in_valid};
		end
	end

	for (genvar o = 0; o < OCT_N; o++) begin : g_oct
		vnh_octave u_oct (
			.clk(clk), .en(en), .octave(3'(o)), .seed(seed_q),
			.cell_x(cell_x), .cell_z(cell_z), .n(n_o[o])
		);
	end

	always_comb begin
		w_c = '0;
		for (int o = 0; o < OCT_N; o++) begin
			w_c = w_c + (SUM_W'(n_o[o]) << (6 - o));
		end
	end

	assign t3 = w_s12 + (w_s12 << 1);

	always_ff @(posedge clk) begin
		if (en) begin
			w_s12 <= w_c;
			height_s13 <= 5'(t3[SUM_W-1:66] + 8'd1);
		end
	end

	assign out_valid = vld_s[TOP_LAT-1];
	assign height = height_s13;
endmodule

/* rtl/vnh_hash.sv */
// One lattice corner hash: seeded multiply-add chain and squaring modulo 2^32 - 5.
// Six register stages; depends on vnh_pkg.
`timescale 1ns / 1ps
module vnh_hash (
	input  logic           clk,
	input  logic           en,
	input  vnh_pkg::word_t seed,
	input  vnh_pkg::word_t xc,
	input  vnh_pkg::word_t zc,
	output vnh_pkg::word_t h
);
	import vnh_pkg::*;

	logic [63:0] p1_s1, px_s1, p2_s3, pz_s3, sq_s5;
	word_t z_s1, z_s2, h1_s2, h2_s4, h_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= 64'(seed) * 64'(HMUL);
			px_s1 <= 64'(xc) * 64'(HXMUL);
			z_s1 <= zc;
			h1_s2 <= mod_p(p1_s1 + px_s1 + 64'(HADD));
			z_s2 <= z_s1;
			p2_s3 <= 64'(h1_s2) * 64'(HMUL);
			pz_s3 <= 64'(z_s2) * 64'(HZMUL);
			h2_s4 <= mod_p(p2_s3 + pz_s3 + 64'(HADD));
			sq_s5 <= 64'(h2_s4) * 64'(h2_s4);
			h_s6 <= mod_p(sq_s5 + 64'(HADD));
		end
	end

	assign h = h_s6;
endmodule

/* rtl/vnh_octave.sv */
// One noise layer: lattice split, four corner hashes and smoothstep bilinear blend.
// Result is the layer value scaled by 2^62; depends on vnh_pkg and vnh_hash.
`timescale 1ns / 1ps
module vnh_octave (
	input  logic               clk,
	input  logic               en,
	input  logic [2:0]         octave,
	input  vnh_pkg::word_t     seed,
	input  logic signed [23:0] cell_x,
	input  logic signed [23:0] cell_z,
	output vnh_pkg::layer_t    n
);
	import vnh_pkg::*;

	logic [2:0] sh;
	logic signed [31:0] cx, cz;
	word_t gx, gz;
	word_t gx0_s1, gx1_s1, gz0_s1, gz1_s1;
	logic [4:0] kx_s1, kz_s1;
	logic [4:0] kx_d [HASH_LAT];
	logic [4:0] kz_d [HASH_LAT];
	word_t ha, hb, hc, hd;

	assign sh = 3'd5 - octave;
	assign cx = 32'(cell_x);
	assign cz = 32'(cell_z);
	assign gx = $unsigned(cx >>> sh) + 32'(octave) * XOFF;
	assign gz = $unsigned(cz >>> sh) + 32'(octave) * ZOFF;

	always_ff @(posedge clk) begin
		if (en) begin
			gx0_s1 <= gx;
			gx1_s1 <= gx + 32'd1;
			gz0_s1 <= gz;
			gz1_s1 <= gz + 32'd1;
			kx_s1 <= 5'(cell_x[4:0] << octave);
			kz_s1 <= 5'(cell_z[4:0] << octave);
			kx_d[0] <= kx_s1;
			kz_d[0] <= kz_s1;
			for (int i = 1; i < HASH_LAT; i++) begin
				kx_d[i] <= kx_d[i-1];
				kz_d[i] <= kz_d[i-1];
			end
		end
	end

	vnh_hash u_ha (.clk(clk), .en(en), .seed(seed), .xc(gx0_s1), .zc(gz0_s1), .h(ha));
	vnh_hash u_hb (.clk(clk), .en(en), .seed(seed), .xc(gx1_s1), .zc(gz0_s1), .h(hb));
	vnh_hash u_hc (.clk(clk), .en(en), .seed(seed), .xc(gx0_s1), .zc(gz1_s1), .h(hc));
	vnh_hash u_hd (.clk(clk), .en(en), .seed(seed), .xc(gx1_s1), .zc(gz1_s1), .h(hd));

	logic signed [32:0] dab, dcd;
	logic signed [15:0] u_w, v_w;
	logic signed [48:0] pb_l1, pd_l1, top_l2, bot_l2, top_l3;
	word_t a_l1, c_l1;
	logic [14:0] v_l1, v_l2;
	logic signed [49:0] dtb;
	logic signed [65:0] pv_l3;
	logic signed [65:0] n_sum;
	layer_t n_l4;

	assign dab = $signed({1'b0, hb}) - $signed({1'b0, ha});
	assign dcd = $signed({1'b0, hd}) - $signed({1'b0, hc});
	assign u_w = $signed({1'b0, smooth(kx_d[HASH_LAT-1])});
	assign v_w = $signed({1'b0, v_l2});
	assign dtb = 50'(bot_l2) - 50'(top_l2);
	assign n_sum = $signed({2'b0, top_l3[46:0], 15'b0}) + pv_l3;

	always_ff @(posedge clk) begin
		if (en) begin
			pb_l1 <= 49'(dab) * 49'(u_w);
			pd_l1 <= 49'(dcd) * 49'(u_w);
			a_l1 <= ha;
			c_l1 <= hc;
			v_l1 <= smooth(kz_d[HASH_LAT-1]);
			top_l2 <= $signed({2'b0, a_l1, 15'b0}) + pb_l1;
			bot_l2 <= $signed({2'b0, c_l1, 15'b0}) + pd_l1;
			v_l2 <= v_l1;
			pv_l3 <= 66'(dtb) * 66'(v_w);
			top_l3 <= top_l2;
			n_l4 <= n_sum[61:0];
		end
	end

	assign n = n_l4;
endmodule

/* rtl/vnh_checker.sv */
// Port checker for the value noise heightmap unit, bound to the top level.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
module vnh_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [4:0]         height,
	input logic               cfg_ready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(height))
		else $error("Stalled result changed.");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("Input stalled without a stalled result.");

	a_height: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> height != 5'd0 && height <= 5'd21)
		else $error("Height out of range.");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("Configuration port not ready.");
endmodule

bind value_noise_heightmap_unit vnh_checker u_vnh_checker (.*);

/* test/value_noise_heightmap_unit_tb.sv */
// Testbench for value_noise_heightmap_unit: streams cell coordinates under several seeds
// and checks every height against an exact fixed-point predictor. Depends on vnh_pkg.
`timescale 1ns / 1ps
module value_noise_heightmap_unit_tb;
	import vnh_pkg::*;

	localparam int RUN_LIMIT = 400000;
	localparam logic [31:0] SEED_MAX = 32'hFFFF_FFFF;
	localparam longint unsigned PRIME = 64'd4294967291;

	typedef struct {
		logic signed [23:0] x;
		logic signed [23:0] z;
		bit                 known;
		logic [4:0]         height;
	} cell_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [23:0] cell_x;
	logic signed [23:0] cell_z;
	logic               out_valid;
	logic               out_stall;
	logic [4:0]         height;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [31:0]        cfg_data;

	logic [31:0] seed_copy;
	logic [4:0]  height_queue[$];
	int          errors;
	int          cells_sent;
	int          heights_seen;
	int          seeds_used;
	int          cycle_count;
	int          stall_mode;
	cell_row_t   cell_table[$];

	value_noise_heightmap_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cell_x   (cell_x),
		.cell_z   (cell_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.height   (height),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned lattice_hash(logic [31:0] s, logic [31:0] gx,
			logic [31:0] gz);
		longint unsigned h;
		h = 64'(s);
		h = (h * 64'd1103515245 + 64'(gx) * 64'd73856093 + 64'd12345) % PRIME;
		h = (h * 64'd1103515245 + 64'(gz) * 64'd19349663 + 64'd12345) % PRIME;
		h = (h * h + 64'd12345) % PRIME;
		return h;
	endfunction

	function automatic logic [4:0] terrain_height(logic [31:0] s, logic signed [23:0] cx,
			logic signed [23:0] cz);
		longint unsigned qsum, rsum, total, amp;
		longint a, b, c, d, u, v, top, bot, n, kx, kz;
		int xi, zi, gxi, gzi;
		logic [31:0] gx, gz;
		qsum = 0;
		rsum = 0;
		xi = cx;
		zi = cz;
		for (int o = 0; o < OCT_N; o++) begin
			gxi = xi >>> (5 - o);
			gzi = zi >>> (5 - o);
			kx = longint'(xi - (gxi <<< (5 - o))) << o;
			kz = longint'(zi - (gzi <<< (5 - o))) << o;
			gx = 32'(gxi) + 32'(o) * 32'd1013;
			gz = 32'(gzi) + 32'(o) * 32'd7919;
			a = lattice_hash(s, gx, gz);
			b = lattice_hash(s, gx + 32'd1, gz);
			c = lattice_hash(s, gx, gz + 32'd1);
			d = lattice_hash(s, gx + 32'd1, gz + 32'd1);
			u = kx * kx * (96 - 2 * kx);
			v = kz * kz * (96 - 2 * kz);
			top = a * 32768 + (b - a) * u;
			bot = c * 32768 + (d - c) * u;
			n = top * 32768 + (bot - top) * v;
			amp = 64'd192 >> o;
			qsum += (longint'(unsigned'(n)) >> 30) * amp;
			rsum += (n & 64'h3FFF_FFFF) * amp;
		end
		total = (qsum + (rsum >> 30)) >> 36;
		return 5'(total + 1);
	endfunction

	task automatic report_mismatch(string what, logic [4:0] got, logic [4:0] want);
		$display("MISMATCH %s: got %0d, expected %0d at cycle %0d", what, got, want,
			cycle_count);
		errors++;
	endtask

	task automatic send_cell(logic signed [23:0] x, logic signed [23:0] z, bit known,
			logic [4:0] want);
		logic [4:0] predicted;
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cell_x <= x;
		cell_z <= z;
		do @(posedge clk); while (in_stall);
		predicted = terrain_height(seed_copy, x, z);
		if (known && predicted !== want) begin
			report_mismatch("table row", predicted, want);
		end
		height_queue.push_back(known ? want : predicted);
		cells_sent++;
	endtask

	task automatic drain_heights();
		in_valid <= 1'b0;
		while (height_queue.size() != 0) @(posedge clk);
		repeat (TOP_LAT + 4) @(posedge clk);
	endtask

	task automatic write_seed(logic [31:0] s);
		drain_heights();
		cfg_valid <= 1'b1;
		cfg_data <= s;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seed_copy = s;
		seeds_used++;
	endtask

	function automatic logic signed [23:0] random_coord();
		case ($urandom_range(0, 4))
			0: return 24'($urandom_range(0, 255)) - 24'sd128;
			1: return 24'sh7FFFFF - 24'($urandom_range(0, 40));
			2: return 24'sh800000 + 24'($urandom_range(0, 40));
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_random_cells(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(2, 20)) @(posedge clk);
			end
			send_cell(random_coord(), random_coord(), 1'b0, 5'd0);
		end
	endtask

	always @(posedge clk) begin
		logic [4:0] want;
		if (arst_n && out_valid && !out_stall) begin
			heights_seen++;
			if (height_queue.size() == 0) begin
				report_mismatch("unexpected beat", height, 5'd0);
			end else begin
				want = height_queue.pop_front();
				if (height !== want) begin
					report_mismatch("height", height, want);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count % 96 == 0) begin
			stall_mode <= $urandom_range(0, 3);
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (cycle_count % 7 < 2);
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("value_noise_heightmap_unit verification failed");
			$finish;
		end
	end

	initial begin
		static logic signed [23:0] xs[] = '{24'sd0, -24'sd1, 24'sh7FFFFF, 24'sh800000,
			24'sh7FFFFF, 24'sh800000, 24'sd31, 24'sd32, -24'sd32, -24'sd33, 24'sd7, 24'sd1,
			24'sd15, 24'sd100, 24'sh555555, 24'shAAAAAA, 24'sd16, -24'sd31, 24'sd8, 24'sd63};
		static logic signed [23:0] zs[] = '{24'sd0, -24'sd1, 24'sh7FFFFF, 24'sh800000,
			24'sh800000, 24'sh7FFFFF, 24'sd31, 24'sd32, -24'sd32, 24'sd16, 24'sd8, -24'sd1,
			24'sd16, -24'sd100, 24'shAAAAAA, 24'sh555555, -24'sd16, 24'sd64, -24'sd8, -24'sd64};
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cell_x = '0;
		cell_z = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		seed_copy = '0;
		errors = 0;
		cells_sent = 0;
		heights_seen = 0;
		seeds_used = 1;
		cycle_count = 0;
		stall_mode = 0;
		for (int i = 0; i < xs.size(); i++) begin
			cell_table.push_back('{xs[i], zs[i], 1'b0, 5'd0});
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset the seed is zero, so the table runs under the reset seed.
		foreach (cell_table[i]) begin
			send_cell(cell_table[i].x, cell_table[i].z, cell_table[i].known,
				cell_table[i].height);
		end
		send_random_cells(100);
		write_seed(SEED_MAX);
		foreach (cell_table[i]) begin
			send_cell(cell_table[i].x, cell_table[i].z, 1'b0, 5'd0);
		end
		send_random_cells(130);
		write_seed(32'd1);
		send_random_cells(130);
		write_seed(32'hFFFF_FFFB);
		send_random_cells(130);
		for (int p = 0; p < 4; p++) begin
			write_seed($urandom);
			send_random_cells(130);
		end
		write_seed(32'd0);
		send_random_cells(20);

		drain_heights();
		$display("Sent %0d cells under %0d seeds, %0d heights checked, %0d errors.",
			cells_sent, seeds_used, heights_seen, errors);
		if (errors == 0) begin
			$display("value_noise_heightmap_unit verification clean");
		end else begin
			$display("value_noise_heightmap_unit verification failed");
		end
		$finish;
	end

endmodule

/* value_noise_heightmap_unit.f */
rtl/vnh_pkg.sv
rtl/vnh_hash.sv
rtl/vnh_octave.sv
rtl/value_noise_heightmap_unit.sv
rtl/vnh_checker.sv
test/value_noise_heightmap_unit_tb.sv
